@@ hdl/tmfc_pkg.sv @@
// Shared types, codes and helpers for the telemetry frame header and FECF checker.
// Used by tm_frame_header_fecf_check_core, tmfc_frame_monitor and the testbench; depends on nothing else.
package tmfc_pkg;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 12;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_SIZE    = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_FECF_MODE     = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_CHECK_FECF    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_MAC_LENGTH    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_SEC_HDR_LIMIT = 3'd4;

	// Configuration reset values.
	localparam logic [11:0] FRAME_SIZE_RST    = 12'd1024;
	localparam logic [1:0]  FECF_MODE_RST     = 2'd1;
	localparam logic        CHECK_FECF_RST    = 1'b1;
	localparam logic [6:0]  MAC_LENGTH_RST    = 7'd16;
	localparam logic [5:0]  SEC_HDR_LIMIT_RST = 6'd63;

	// FECF modes.
	localparam logic [1:0] FECF_NONE    = 2'd0;
	localparam logic [1:0] FECF_PRESENT = 2'd1;

	// Result status codes.
	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_SHORT       = 3'd1;
	localparam logic [2:0] ST_SEC_VERSION = 3'd2;
	localparam logic [2:0] ST_SEC_SIZE    = 3'd3;
	localparam logic [2:0] ST_UNDERFLOW   = 3'd4;
	localparam logic [2:0] ST_FECF_BAD    = 3'd5;
	localparam logic [2:0] ST_FECF_MODE   = 3'd6;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [1:0]  version_number;
		logic [9:0]  spacecraft_id;
		logic [2:0]  virtual_channel;
		logic [6:0]  secondary_length;
		logic [7:0]  security_index;
		logic [15:0] received_check;
		logic [15:0] computed_check;
	} result_t;

	// CRC-16 update by one byte, MSB first.
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

@@ hdl/tm_frame_header_fecf_check_core.sv @@
// Telemetry transfer frame header parser and FECF (CRC-16) checker, one byte per transfer.
// Depends on tmfc_pkg for payload types, status codes and the CRC byte update.
//
// Path: a frame's last byte is taken into the input register, then its result is loaded
// into the result register and result_valid rises. Throughput: one byte per cycle; only a
// last byte waits, and only while an earlier result is still held by result_stall.
// Reset: arst_n clears the frame state and loads the configuration reset values.
module tm_frame_header_fecf_check_core #(
	parameter int MAX_FRAME_BYTES = 2048
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  tmfc_pkg::item_t                     item,
	output logic                                result_valid,
	input  logic                                result_stall,
	output tmfc_pkg::result_t                   result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tmfc_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [tmfc_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import tmfc_pkg::*;

	localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
	localparam int CMP_W = (CNT_W > 12) ? CNT_W : 12;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME_BYTES);

	// Configuration registers.
	logic [11:0] frame_size_q;
	logic [1:0]  fecf_mode_q;
	logic        check_fecf_q;
	logic [6:0]  mac_length_q;
	logic [5:0]  sec_hdr_limit_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_size_q    <= FRAME_SIZE_RST;
			fecf_mode_q     <= FECF_MODE_RST;
			check_fecf_q    <= CHECK_FECF_RST;
			mac_length_q    <= MAC_LENGTH_RST;
			sec_hdr_limit_q <= SEC_HDR_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_FRAME_SIZE:    frame_size_q    <= cfg_data[11:0];
				CFG_FECF_MODE:     fecf_mode_q     <= cfg_data[1:0];
				CFG_CHECK_FECF:    check_fecf_q    <= cfg_data[0];
				CFG_MAC_LENGTH:    mac_length_q    <= cfg_data[6:0];
				CFG_SEC_HDR_LIMIT: sec_hdr_limit_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// Input register stage.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       out_free;
	logic       adv;

	assign out_free   = !result_valid || !result_stall;
	assign adv        = valid_s1 && (!last_s1 || out_free);
	assign item_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			byte_s1 <= item.data_byte;
			last_s1 <= item.last_byte;
		end
	end

	// Frame state.
	logic [CNT_W-1:0] pos_q;
	logic [15:0]      crc_q;
	logic [7:0]       dly0_q, dly1_q;
	logic [7:0]       hdr0_q, hdr1_q;
	logic             sec_present_q;
	logic [6:0]       sec_bytes_q;
	logic [15:0]      index_q;
	logic [15:0]      fecf_q;
	logic [2:0]       hdr_err_q;

	logic [CNT_W-1:0] pos_n;
	logic [15:0]      crc_n;
	logic [7:0]       hdr0_n, hdr1_n;
	logic             sec_present_n;
	logic [6:0]       sec_bytes_n;
	logic [15:0]      index_n;
	logic [15:0]      fecf_n;
	logic [2:0]       hdr_err_n;
	logic [6:0]       spi_n;
	logic [CMP_W-1:0] pos_x, len_x, fs_x;
	logic             pos_below_max;
	logic [2:0]       status_n;

	always_comb begin
		pos_x         = CMP_W'(pos_q);
		fs_x          = CMP_W'(frame_size_q);
		pos_below_max = (pos_q < CNT_MAX);

		hdr0_n        = hdr0_q;
		hdr1_n        = hdr1_q;
		sec_present_n = sec_present_q;
		sec_bytes_n   = sec_bytes_q;
		hdr_err_n     = hdr_err_q;
		index_n       = index_q;
		fecf_n        = fecf_q;
		spi_n         = sec_present_q ? (7'd6 + sec_bytes_q) : 7'd6;

		if (pos_x == CMP_W'(0)) hdr0_n = byte_s1;
		if (pos_x == CMP_W'(1)) hdr1_n = byte_s1;
		if (pos_x == CMP_W'(4)) sec_present_n = byte_s1[7];
		if (pos_x == CMP_W'(6) && sec_present_q) begin
			sec_bytes_n = {1'b0, byte_s1[5:0]} + 7'd1;
			if (byte_s1[7:6] != 2'b00) begin
				hdr_err_n = ST_SEC_VERSION;
			end else if (sec_bytes_n > ({1'b0, sec_hdr_limit_q} + 7'd1)) begin
				hdr_err_n = ST_SEC_SIZE;
			end
			spi_n = 7'd6 + sec_bytes_n;
		end

		// Security parameter index follows the secondary header, high byte first.
		if (pos_x >= CMP_W'(6) && pos_x == CMP_W'(spi_n)) index_n[15:8] = byte_s1;
		if (pos_x >= CMP_W'(7) && pos_x == CMP_W'(spi_n) + CMP_W'(1)) index_n[7:0] = byte_s1;

		if (pos_below_max && frame_size_q >= 12'd2) begin
			if (pos_x == fs_x - CMP_W'(2)) fecf_n[15:8] = byte_s1;
			if (pos_x == fs_x - CMP_W'(1)) fecf_n[7:0]  = byte_s1;
		end

		// The two newest bytes are held back; the last two never enter the CRC.
		crc_n = (pos_x >= CMP_W'(2)) ? crc16_byte(crc_q, dly0_q) : crc_q;

		pos_n = pos_below_max ? (pos_q + CNT_W'(1)) : pos_q;
		len_x = CMP_W'(pos_n);

		if (len_x < CMP_W'(6)) begin
			status_n = ST_SHORT;
		end else if (sec_present_n && hdr_err_n != ST_OK) begin
			status_n = hdr_err_n;
		end else if (sec_present_n && len_x < (CMP_W'(7) + CMP_W'(sec_bytes_n))) begin
			status_n = ST_SEC_SIZE;
		end else if ((13'(frame_size_q) + 13'(mac_length_q)) <= (13'(spi_n) + 13'd2)) begin
			status_n = ST_UNDERFLOW;
		end else if (len_x < fs_x) begin
			status_n = ST_UNDERFLOW;
		end else if (fecf_mode_q == FECF_PRESENT) begin
			status_n = (check_fecf_q && crc_n != fecf_n) ? ST_FECF_BAD : ST_OK;
		end else if (fecf_mode_q == FECF_NONE) begin
			status_n = ST_OK;
		end else begin
			status_n = ST_FECF_MODE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q         <= '0;
			crc_q         <= CRC_INIT;
			dly0_q        <= '0;
			dly1_q        <= '0;
			hdr0_q        <= '0;
			hdr1_q        <= '0;
			sec_present_q <= 1'b0;
			sec_bytes_q   <= '0;
			index_q       <= '0;
			fecf_q        <= '0;
			hdr_err_q     <= ST_OK;
		end else if (adv) begin
			if (last_s1) begin
				pos_q         <= '0;
				crc_q         <= CRC_INIT;
				dly0_q        <= '0;
				dly1_q        <= '0;
				hdr0_q        <= '0;
				hdr1_q        <= '0;
				sec_present_q <= 1'b0;
				sec_bytes_q   <= '0;
				index_q       <= '0;
				fecf_q        <= '0;
				hdr_err_q     <= ST_OK;
			end else begin
				pos_q         <= pos_n;
				crc_q         <= crc_n;
				dly0_q        <= dly1_q;
				dly1_q        <= byte_s1;
				hdr0_q        <= hdr0_n;
				hdr1_q        <= hdr1_n;
				sec_present_q <= sec_present_n;
				sec_bytes_q   <= sec_bytes_n;
				index_q       <= index_n;
				fecf_q        <= fecf_n;
				hdr_err_q     <= hdr_err_n;
			end
		end
	end

	// Result register.
	logic    result_valid_q;
	result_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			result_q.status           <= status_n;
			result_q.version_number   <= hdr0_n[7:6];
			result_q.spacecraft_id    <= {hdr0_n[5:0], hdr1_n[7:4]};
			result_q.virtual_channel  <= hdr1_n[3:1];
			result_q.secondary_length <= sec_present_n ? sec_bytes_n : 7'd0;
			result_q.security_index   <= index_n[7:0];
			result_q.received_check   <= fecf_n;
			result_q.computed_check   <= crc_n;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// A frame's last byte always leaves the state cleared for the next frame.
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && last_s1) |=> (pos_q == '0 && crc_q == CRC_INIT && !sec_present_q))
		else $error("frame state not cleared after last byte");

	// Every processed last byte yields a result in the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && last_s1) |=> result_valid)
		else $error("missing result after last byte");

	// Back-pressure on the input only comes from a held last byte.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (valid_s1 && last_s1 && result_valid && result_stall))
		else $error("input stalled without a pending result");

	// The byte counter never passes its saturation value.
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= CNT_MAX)
		else $error("byte counter beyond saturation");

endmodule

@@ sim/tmfc_frame_monitor.sv @@
`timescale 1ns / 1ps
// Watches the byte, result and register channels of tm_frame_header_fecf_check_core.
// It predicts every frame's result from its own model and compares each field with the block.
// Depends on tmfc_pkg for the payload types, register indexes and status codes.
module tmfc_frame_monitor #(
	parameter int MAX_FRAME_BYTES = 2048
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	input  logic                             item_stall,
	input  tmfc_pkg::item_t                  item,
	input  logic                             result_valid,
	input  logic                             result_stall,
	input  tmfc_pkg::result_t                result,
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  logic [tmfc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [tmfc_pkg::CFG_DATA_W-1:0]  cfg_data,
	output int                               pending,
	output int                               errors
);
	import tmfc_pkg::*;

	// Register copies.
	logic [11:0] frame_size_q;
	logic [1:0]  fecf_mode_q;
	logic        check_fecf_q;
	logic [6:0]  mac_length_q;
	logic [5:0]  sec_limit_q;

	// Per-frame parse state.
	logic [11:0] nbytes;
	logic [15:0] crc_acc;
	logic [7:0]  held [2];
	logic [7:0]  hdr [2];
	logic        sec_on;
	logic [6:0]  sec_len;
	logic [15:0] spi;
	logic [15:0] fecf_rx;
	logic [2:0]  hdr_err;

	result_t due_results [$];
	result_t want;
	int      seen;

	function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		logic        fb;
		c = crc;
		for (int k = 7; k >= 0; k--) begin
			fb = c[15] ^ b[k];
			c = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
		end
		return c;
	endfunction

	task automatic clear_frame();
		nbytes = '0;
		crc_acc = CRC_INIT;
		held[0] = '0;
		held[1] = '0;
		hdr[0] = '0;
		hdr[1] = '0;
		sec_on = 1'b0;
		sec_len = '0;
		spi = '0;
		fecf_rx = '0;
		hdr_err = ST_OK;
	endtask

	// Advances the parse state by one frame byte; the last byte queues the status it earns.
	task automatic absorb_byte(input logic [7:0] b, input logic fin);
		int      pos;
		int      spi_at;
		int      len;
		int      fs;
		int      mac;
		logic [2:0] st;
		result_t r;
		pos = nbytes;
		fs = frame_size_q;
		mac = mac_length_q;
		spi_at = sec_on ? 6 + sec_len : 6;
		if (pos == 0) hdr[0] = b;
		if (pos == 1) hdr[1] = b;
		if (pos == 4) sec_on = b[7];
		if (pos == 6 && sec_on) begin
			sec_len = {1'b0, b[5:0]} + 7'd1;
			if (b[7:6] != 2'b00) begin
				hdr_err = ST_SEC_VERSION;
			end else if (sec_len > {1'b0, sec_limit_q} + 7'd1) begin
				hdr_err = ST_SEC_SIZE;
			end
			spi_at = 6 + sec_len;
		end
		if (pos >= 6 && pos == spi_at) spi[15:8] = b;
		if (pos >= 7 && pos == spi_at + 1) spi[7:0] = b;
		// Past the saturation point no FECF byte is captured.
		if (pos < MAX_FRAME_BYTES && fs >= 2) begin
			if (pos == fs - 2) fecf_rx[15:8] = b;
			if (pos == fs - 1) fecf_rx[7:0] = b;
		end
		// The CRC trails the input by two bytes; the last two never enter it.
		if (pos >= 2) crc_acc = crc_step(crc_acc, held[0]);
		held[0] = held[1];
		held[1] = b;
		len = (pos < MAX_FRAME_BYTES) ? pos + 1 : pos;
		nbytes = len[11:0];
		if (fin) begin
			if (len < 6) begin
				st = ST_SHORT;
			end else if (sec_on && hdr_err != ST_OK) begin
				st = hdr_err;
			end else if (sec_on && len < 7 + sec_len) begin
				st = ST_SEC_SIZE;
			end else if (fs <= spi_at + 2 - mac) begin
				st = ST_UNDERFLOW;
			end else if (len < fs) begin
				st = ST_UNDERFLOW;
			end else if (fecf_mode_q == FECF_PRESENT) begin
				st = (check_fecf_q && crc_acc != fecf_rx) ? ST_FECF_BAD : ST_OK;
			end else if (fecf_mode_q == FECF_NONE) begin
				st = ST_OK;
			end else begin
				st = ST_FECF_MODE;
			end
			r.status = st;
			r.version_number = hdr[0][7:6];
			r.spacecraft_id = {hdr[0][5:0], hdr[1][7:4]};
			r.virtual_channel = hdr[1][3:1];
			r.secondary_length = sec_on ? sec_len : 7'd0;
			r.security_index = spi[7:0];
			r.received_check = fecf_rx;
			r.computed_check = crc_acc;
			due_results.push_back(r);
			clear_frame();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_size_q = FRAME_SIZE_RST;
			fecf_mode_q = FECF_MODE_RST;
			check_fecf_q = CHECK_FECF_RST;
			mac_length_q = MAC_LENGTH_RST;
			sec_limit_q = SEC_HDR_LIMIT_RST;
			clear_frame();
			due_results.delete();
			pending = 0;
			errors = 0;
			seen = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_FRAME_SIZE:    frame_size_q = cfg_data[11:0];
					CFG_FECF_MODE:     fecf_mode_q = cfg_data[1:0];
					CFG_CHECK_FECF:    check_fecf_q = cfg_data[0];
					CFG_MAC_LENGTH:    mac_length_q = cfg_data[6:0];
					CFG_SEC_HDR_LIMIT: sec_limit_q = cfg_data[5:0];
					default: ;
				endcase
			end
			if (item_valid && !item_stall) begin
				absorb_byte(item.data_byte, item.last_byte);
			end
			if (result_valid && !result_stall) begin
				seen++;
				if (due_results.size() == 0) begin
					errors++;
					if (errors <= 10) begin
						$display("result %0d arrived with no frame ended: %h", seen, result);
					end
				end else begin
					want = due_results.pop_front();
					if (result.status !== want.status
							|| result.version_number !== want.version_number
							|| result.spacecraft_id !== want.spacecraft_id
							|| result.virtual_channel !== want.virtual_channel
							|| result.secondary_length !== want.secondary_length
							|| result.security_index !== want.security_index
							|| result.received_check !== want.received_check
							|| result.computed_check !== want.computed_check) begin
						errors++;
						if (errors <= 10) begin
							$display({"result %0d wrong (expected/actual): status %0d/%0d ",
								"version %0d/%0d scid %0d/%0d vc %0d/%0d sec %0d/%0d ",
								"spi %h/%h fecf %h/%h crc %h/%h"}, seen,
								want.status, result.status,
								want.version_number, result.version_number,
								want.spacecraft_id, result.spacecraft_id,
								want.virtual_channel, result.virtual_channel,
								want.secondary_length, result.secondary_length,
								want.security_index, result.security_index,
								want.received_check, result.received_check,
								want.computed_check, result.computed_check);
						end
					end
				end
			end
			pending = due_results.size();
		end
	end

endmodule

@@ sim/tm_frame_header_fecf_check_core_tb.sv @@
`timescale 1ns / 1ps
// Top of the testbench for tm_frame_header_fecf_check_core: clock, reset, frame and
// register stimulus, random gaps and stalls. Checking lives in tmfc_frame_monitor.
module tm_frame_header_fecf_check_core_tb;
	import tmfc_pkg::*;

	// Register index the block does not decode.
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 3'd7;
	// FECF mode values that the block must reject.
	localparam logic [1:0] FECF_BAD_TWO   = 2'd2;
	localparam logic [1:0] FECF_BAD_THREE = 2'd3;

	logic                   clk;
	logic                   arst_n;
	logic                   item_valid;
	logic                   item_stall;
	item_t                  item;
	logic                   result_valid;
	logic                   result_stall;
	result_t                result;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	int                     pending;
	int                     errors;

	bit          idle_on;
	bit          quiet;
	logic [7:0]  frame_q [$];
	logic [11:0] fsz_set;
	logic [5:0]  lim_set;

	tm_frame_header_fecf_check_core #(
		.MAX_FRAME_BYTES(2048)
	) dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.result_valid(result_valid), .result_stall(result_stall), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	tmfc_frame_monitor #(
		.MAX_FRAME_BYTES(2048)
	) monitor (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.result_valid(result_valid), .result_stall(result_stall), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.pending(pending), .errors(errors)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Result side stalls in random bursts.
	initial begin
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (idle_on && $urandom_range(0, 5) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 13)) @(negedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	initial begin
		#10_000_000;
		$display("tm_frame_header_fecf_check_core: mismatch");
		$finish;
	end

	function automatic logic [15:0] crc_of(input int n);
		logic [15:0] c;
		c = CRC_INIT;
		for (int i = 0; i < n; i++) begin
			c ^= {frame_q[i], 8'h00};
			for (int k = 0; k < 8; k++) begin
				c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

	task automatic seal_frame();
		logic [15:0] fcs;
		int          n;
		n = frame_q.size();
		if (n >= 2) begin
			fcs = crc_of(n - 2);
			frame_q[n - 2] = fcs[15:8];
			frame_q[n - 1] = fcs[7:0];
		end
	endtask

	// A sound frame has a clean secondary header that fits and a matching FECF;
	// anything else is random bytes with the FECF right only half the time.
	task automatic build_frame(input int n, input bit sound);
		int         span;
		logic [5:0] coded;
		frame_q.delete();
		repeat (n) frame_q.push_back(8'($urandom));
		if (sound) begin
			if (n > 4) frame_q[4] = {1'b0, frame_q[4][6:0]};
			if (n >= 10 && $urandom_range(0, 1) == 1) begin
				span = (n - 10 < lim_set) ? n - 10 : lim_set;
				coded = 6'($urandom_range(0, span));
				frame_q[4] = {1'b1, frame_q[4][6:0]};
				frame_q[6] = {2'b00, coded};
			end
			seal_frame();
		end else if ($urandom_range(0, 1) == 1) begin
			seal_frame();
		end
	endtask

	task automatic push_byte(input logic [7:0] b, input logic fin);
		if (idle_on && !quiet && $urandom_range(0, 7) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		item_valid <= 1'b1;
		item <= {b, fin};
		@(posedge clk);
		while (item_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic send_frame();
		quiet = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < frame_q.size(); i++) begin
			push_byte(frame_q[i], i == frame_q.size() - 1);
		end
		// Now and then hold off until every status is back.
		if ($urandom_range(0, 9) == 0) drain();
	endtask

	// Writes every register, with junk above every field but the full-width frame size, plus one undecoded index.
	task automatic configure(input logic [11:0] fsz, input logic [1:0] mode, input logic chk,
			input logic [6:0] mac, input logic [5:0] lim);
		logic [CFG_INDEX_W-1:0] idx [6];
		logic [CFG_DATA_W-1:0]  val [6];
		drain();
		idx = '{CFG_FRAME_SIZE, CFG_FECF_MODE, CFG_CHECK_FECF, CFG_MAC_LENGTH,
			CFG_SEC_HDR_LIMIT, CFG_SPARE};
		val = '{fsz, {10'($urandom), mode}, {11'($urandom), chk}, {5'($urandom), mac},
			{6'($urandom), lim}, 12'($urandom)};
		for (int i = 0; i < 6; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
		fsz_set = fsz;
		lim_set = lim;
	endtask

	task automatic run_frames(input int bytes_wanted, input int frames_wanted);
		int sent;
		int frames;
		int span;
		sent = 0;
		frames = 0;
		while (sent < bytes_wanted || frames < frames_wanted) begin
			span = (fsz_set >= 6 && fsz_set <= 40) ? fsz_set : $urandom_range(6, 20);
			if ($urandom_range(0, 3) != 0) begin
				build_frame(span, 1'b1);
			end else begin
				build_frame($urandom_range(1, 40), 1'b0);
			end
			sent += frame_q.size();
			frames++;
			send_frame();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		idle_on = 1'b1;
		quiet = 1'b0;
		fsz_set = FRAME_SIZE_RST;
		lim_set = SEC_HDR_LIMIT_RST;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: a lone byte, a frame one byte short of a header, and a
		// secondary header with a nonzero version.
		frame_q = '{8'hFF};
		send_frame();
		frame_q = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
		send_frame();
		frame_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h80, 8'h00, 8'hC5, 8'h00};
		send_frame();

		// A ten-byte frame that passes every check, header fields at their maximum.
		configure(12'd10, FECF_PRESENT, 1'b1, 7'd0, 6'd63);
		frame_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00};
		seal_frame();
		send_frame();

		for (int ph = 0; ph < 10; ph++) begin
			case (ph)
				0: configure(12'd12, FECF_PRESENT, 1'b1, 7'd0, 6'd63);
				1: configure(12'd16, FECF_NONE, 1'b0, 7'd64, 6'd0);
				2: configure(12'd0, FECF_PRESENT, 1'b1, 7'd16, 6'd10);
				3: configure(12'd1, FECF_BAD_TWO, 1'b1, 7'd127, 6'd0);
				4: configure(12'd9, FECF_BAD_THREE, 1'b0, 7'd3, 6'd3);
				default: configure(12'($urandom_range(9, 28)),
					($urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 3)) : FECF_PRESENT,
					1'($urandom_range(0, 1)), 7'($urandom_range(0, 64)),
					6'($urandom_range(0, 63)));
			endcase
			run_frames(30, 3);
		end

		// Largest and out-of-range frame sizes, against which short frames underflow.
		configure(12'd2048, FECF_PRESENT, 1'b1, 7'd0, 6'd63);
		run_frames(20, 2);
		configure(12'hFFF, FECF_NONE, 1'b0, 7'd0, 6'd63);
		run_frames(20, 2);

		// Closing stretch at full rate on both sides.
		configure(12'd20, FECF_PRESENT, 1'b1, 7'd3, 6'd63);
		idle_on = 1'b0;
		run_frames(60, 3);

		drain();
		repeat (6) @(negedge clk);
		if (errors == 0) begin
			$display("tm_frame_header_fecf_check_core: match");
		end else begin
			$display("tm_frame_header_fecf_check_core: mismatch");
		end
		$finish;
	end

endmodule
